// File: sv/lc3b_pkg.sv
// Shared types and constants for the LC-3b instruction executor.
// No dependencies.
package lc3b_pkg;

   typedef enum logic [2:0] {
      KIND_WRITE   = 3'd0,
      KIND_READ    = 3'd1,
      KIND_REGRD   = 3'd2,
      KIND_RESTART = 3'd3,
      KIND_EXEC    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      OP_BR  = 4'd0,
      OP_ADD = 4'd1,
      OP_LDB = 4'd2,
      OP_STB = 4'd3,
      OP_JSR = 4'd4,
      OP_AND = 4'd5,
      OP_LDW = 4'd6,
      OP_STW = 4'd7,
      OP_XOR = 4'd9,
      OP_JMP = 4'd12,
      OP_SHF = 4'd13,
      OP_LEA = 4'd14,
      OP_TRAP = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_DECODE,
      ST_MEMRD,
      ST_FINISH
   } state_type;

endpackage

// File: sv/lc3b_instruction_executor_core.sv
// LC-3b instruction executor top level: memory, register file, sequencer.
// Depends on lc3b_pkg.
//
// Usage: pulse start with req_kind and its fields while busy is low. The
// request is taken at that edge; busy stays high until the response strobe.
// Exactly one response per request: rsp_valid is high for one cycle carrying
// read_data, pc_now, the N/Z/P flags and halted. The receiver cannot stall.
// States per request: memory write and register read respond from the
// fetch state, memory read and restart go on to the finish state, and execute
// steps through fetch, decode, address and data read, finish for every opcode.
// Loads, stores and TRAP use the address step for a second memory read (byte
// stores then do a read-modify-write of the addressed word). Halted execution
// responds from the fetch state. One request is taken at a time; the next
// request can be taken in the strobe cycle.
// csr_we writes start_pc (loaded into the PC by a restart request).
// After reset the block runs a clearing pass over all MEM_WORDS words of the
// memory, one word per cycle, with busy high; the registers and PC come
// up zero, Z set.
module lc3b_instruction_executor_core
   import lc3b_pkg::*;
#(
   parameter int MEM_WORDS = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [15:0] req_write_data,
   input  logic [2:0]  req_reg_index,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [15:0] rsp_read_data,
   output logic [15:0] rsp_pc_now,
   output logic        rsp_flag_n,
   output logic        rsp_flag_z,
   output logic        rsp_flag_p,
   output logic        rsp_halted
);

   localparam int AW = $clog2(MEM_WORDS);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] rf_ff [8];

   state_type   state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [15:0] pc_ff, pc_in, start_pc_ff;
   logic        n_ff, z_ff, p_ff, halt_ff, n_in, z_in, p_in, halt_in;
   logic [2:0]  kind_ff;
   logic [15:0] addr_ff, wdata_ff, ir_ff, ir_in, ea_ff, ea_in;
   logic [2:0]  ridx_ff;
   logic [15:0] rdata_ff, rdata_in, mrd_ff;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [15:0]   mem_wd;

   logic          rf_we, rf_clr;
   logic [2:0]    rf_wa;
   logic [15:0]   rf_wd;
   logic          cc_we;
   logic          valid_in;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mrd_ff <= mem[mem_ra];
   end

   function automatic logic [AW-1:0] widx(input logic [15:0] a);
      logic [15:0] w;
      w = {1'b0, a[15:1]};
      return w[AW-1:0];
   endfunction

   function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
      logic [15:0] r;
      for (int i = 0; i < 16; i++) r[i] = (i < bits) ? v[i] : v[bits-1];
      return r;
   endfunction

   logic [3:0]  op;
   logic [2:0]  dr, sr1;
   logic [15:0] a, b, pc2, res, lb;
   logic [15:0] off6, off9, off11;
   opcode_type  opc;
   assign op    = ir_ff[15:12];
   assign opc   = opcode_type'(op);
   assign dr    = ir_ff[11:9];
   assign sr1   = ir_ff[8:6];
   assign a     = rf_ff[sr1];
   assign b     = ir_ff[5] ? sx(ir_ff, 5) : rf_ff[ir_ff[2:0]];
   assign pc2   = pc_ff + 16'd2;
   assign off6  = sx(ir_ff, 6);
   assign off9  = sx(ir_ff, 9);
   assign off11 = sx(ir_ff, 11);
   assign lb    = ea_ff[0] ? sx({8'd0, mrd_ff[15:8]}, 8) : sx({8'd0, mrd_ff[7:0]}, 8);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pc_in    = pc_ff;
      halt_in  = halt_ff;
      ir_in    = ir_ff;
      ea_in    = ea_ff;
      rdata_in = rdata_ff;
      mem_we = 1'b0; mem_re = 1'b0;
      mem_wa = widx(addr_ff); mem_ra = widx(addr_ff); mem_wd = wdata_ff;
      rf_we = 1'b0; rf_clr = 1'b0; rf_wa = dr; rf_wd = 16'd0;
      cc_we = 1'b0; res = 16'd0;
      valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[AW-1:0];
            mem_wd = 16'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            rdata_in = 16'd0;
            case (kind_ff)
               KIND_WRITE: begin
                  mem_we = 1'b1; valid_in = 1'b1; state_in = ST_IDLE;
               end
               KIND_READ: begin
                  mem_re = 1'b1; state_in = ST_FINISH;
               end
               KIND_REGRD: begin
                  rdata_in = rf_ff[ridx_ff]; valid_in = 1'b1; state_in = ST_IDLE;
               end
               KIND_RESTART: begin
                  rf_clr = 1'b1; pc_in = start_pc_ff; halt_in = 1'b0;
                  state_in = ST_FINISH;
               end
               KIND_EXEC: begin
                  if (halt_ff) begin
                     valid_in = 1'b1; state_in = ST_IDLE;
                  end else if (pc_ff == 16'd0) begin
                     halt_in = 1'b1; valid_in = 1'b1; state_in = ST_IDLE;
                  end else begin
                     mem_re = 1'b1; mem_ra = widx(pc_ff); state_in = ST_DECODE;
                  end
               end
               default: begin
                  valid_in = 1'b1; state_in = ST_IDLE;
               end
            endcase
         end
         ST_DECODE: begin
            ir_in = mrd_ff;
            state_in = ST_MEMRD;
         end
         ST_MEMRD: begin
            // address computation and the optional data read
            state_in = ST_FINISH;
            case (opc)
               OP_LDB, OP_STB: begin
                  ea_in = a + off6; mem_re = 1'b1; mem_ra = widx(a + off6);
               end
               OP_LDW, OP_STW: begin
                  ea_in = a + {off6[14:0], 1'b0};
                  mem_re = 1'b1; mem_ra = widx(a + {off6[14:0], 1'b0});
               end
               OP_TRAP: begin
                  mem_re = 1'b1; mem_ra = widx({7'd0, ir_ff[7:0], 1'b0});
               end
               default: ;
            endcase
         end
         ST_FINISH: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
            if (kind_ff == KIND_READ) begin
               rdata_in = mrd_ff;
            end else if (kind_ff == KIND_EXEC) begin
               pc_in = pc2;
               case (opc)
                  OP_BR: if ((ir_ff[11] & n_ff) | (ir_ff[10] & z_ff) | (ir_ff[9] & p_ff))
                     pc_in = pc2 + {off9[14:0], 1'b0};
                  OP_ADD: begin res = a + b; rf_we = 1'b1; cc_we = 1'b1; end
                  OP_AND: begin res = a & b; rf_we = 1'b1; cc_we = 1'b1; end
                  OP_XOR: begin res = a ^ b; rf_we = 1'b1; cc_we = 1'b1; end
                  OP_LDB: begin res = lb; rf_we = 1'b1; cc_we = 1'b1; end
                  OP_LDW: begin res = mrd_ff; rf_we = 1'b1; cc_we = 1'b1; end
                  OP_STB: begin
                     mem_we = 1'b1; mem_wa = widx(ea_ff);
                     mem_wd = ea_ff[0] ? {rf_ff[dr][7:0], mrd_ff[7:0]}
                                       : {mrd_ff[15:8], rf_ff[dr][7:0]};
                  end
                  OP_STW: begin
                     mem_we = 1'b1; mem_wa = widx(ea_ff); mem_wd = rf_ff[dr];
                  end
                  OP_JSR: begin
                     rf_we = 1'b1; rf_wa = 3'd7; res = pc2;
                     pc_in = ir_ff[11] ? pc2 + {off11[14:0], 1'b0} : a;
                  end
                  OP_JMP: pc_in = a;
                  OP_SHF: begin
                     if (!ir_ff[4]) res = a << ir_ff[3:0];
                     else if (!ir_ff[5]) res = a >> ir_ff[3:0];
                     else res = 16'($signed(a) >>> ir_ff[3:0]);
                     rf_we = 1'b1; cc_we = 1'b1;
                  end
                  OP_LEA: begin
                     res = pc2 + {off9[14:0], 1'b0}; rf_we = 1'b1;
                  end
                  OP_TRAP: begin
                     rf_we = 1'b1; rf_wa = 3'd7; res = pc2; pc_in = mrd_ff;
                  end
                  default: pc_in = pc_ff;
               endcase
               rf_wd = res;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      n_in = n_ff; z_in = z_ff; p_in = p_ff;
      if (rf_clr) begin
         n_in = 1'b0; z_in = 1'b1; p_in = 1'b0;
      end else if (cc_we) begin
         n_in = res[15]; z_in = (res == 16'd0); p_in = !res[15] && (res != 16'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pc_ff       <= 16'd0;
         n_ff        <= 1'b0;
         z_ff        <= 1'b1;
         p_ff        <= 1'b0;
         halt_ff     <= 1'b0;
         start_pc_ff <= 16'd0;
         rsp_valid   <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= 16'd0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pc_ff     <= pc_in;
         n_ff      <= n_in;
         z_ff      <= z_in;
         p_ff      <= p_in;
         halt_ff   <= halt_in;
         rsp_valid <= valid_in;
         if (csr_we) start_pc_ff <= csr_wdata;
         if (rf_clr) begin
            for (int i = 0; i < 8; i++) rf_ff[i] <= 16'd0;
         end else if (rf_we) begin
            rf_ff[rf_wa] <= rf_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
         ridx_ff  <= req_reg_index;
      end
      ir_ff    <= ir_in;
      ea_ff    <= ea_in;
      rdata_ff <= rdata_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_read_data = rdata_ff;
   assign rsp_pc_now    = pc_ff;
   assign rsp_flag_n    = n_ff;
   assign rsp_flag_z    = z_ff;
   assign rsp_flag_p    = p_ff;
   assign rsp_halted    = halt_ff;

endmodule

// File: sim/lc3b_instruction_executor_core_tb.sv
// Testbench for the LC-3b instruction executor core: directed and random requests,
// checked against a behavioral machine model kept in the bench. Depends on lc3b_pkg.
`timescale 1ns / 1ps

module lc3b_instruction_executor_core_tb;
   import lc3b_pkg::*;

   localparam int MEM_WORDS = 32768;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] pc_now;
      logic        n;
      logic        z;
      logic        p;
      logic        halted;
   } status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_address = '0;
   logic [15:0] req_write_data = '0;
   logic [2:0]  req_reg_index = '0;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [15:0] rsp_read_data, rsp_pc_now;
   logic        rsp_flag_n, rsp_flag_z, rsp_flag_p, rsp_halted;

   lc3b_instruction_executor_core #(.MEM_WORDS(MEM_WORDS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_address(req_address),
      .req_write_data(req_write_data), .req_reg_index(req_reg_index),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_pc_now(rsp_pc_now), .rsp_flag_n(rsp_flag_n),
      .rsp_flag_z(rsp_flag_z), .rsp_flag_p(rsp_flag_p),
      .rsp_halted(rsp_halted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // machine model
   logic [15:0] mdl_mem [MEM_WORDS];
   logic [15:0] mdl_reg [8];
   logic [15:0] mdl_pc;
   logic        mdl_n, mdl_z, mdl_p, mdl_halt;
   logic [15:0] mdl_start_pc;

   status_type expected_status_q [$];
   int         errors;
   bit         idle_enable;

   function automatic int widx(logic [15:0] a);
      return int'(a[15:1]) % MEM_WORDS;
   endfunction

   function automatic logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] r;
      r = v;
      for (int i = bits; i < 16; i++) r[i] = v[bits-1];
      return r;
   endfunction

   function automatic void set_result_cc(logic [2:0] r, logic [15:0] v);
      mdl_reg[r] = v;
      mdl_n = v[15];
      mdl_z = (v == 16'h0);
      mdl_p = !v[15] && (v != 16'h0);
   endfunction

   function automatic void model_execute();
      logic [15:0] ir, pc2, a, b, ad, res, tgt;
      logic [2:0]  dr, sr1;
      int          wi;
      if (mdl_halt) return;
      if (mdl_pc == 16'h0) begin
         mdl_halt = 1'b1;
         return;
      end
      ir  = mdl_mem[widx(mdl_pc)];
      dr  = ir[11:9];
      sr1 = ir[8:6];
      pc2 = mdl_pc + 16'd2;
      a   = mdl_reg[sr1];
      b   = ir[5] ? sx(ir, 5) : mdl_reg[ir[2:0]];
      case (ir[15:12])
         OP_BR: begin
            if ((ir[11] && mdl_n) || (ir[10] && mdl_z) || (ir[9] && mdl_p))
               mdl_pc = pc2 + (sx(ir, 9) << 1);
            else
               mdl_pc = pc2;
         end
         OP_ADD: begin set_result_cc(dr, a + b); mdl_pc = pc2; end
         OP_AND: begin set_result_cc(dr, a & b); mdl_pc = pc2; end
         OP_XOR: begin set_result_cc(dr, a ^ b); mdl_pc = pc2; end
         OP_LDB: begin
            ad  = a + sx(ir, 6);
            res = mdl_mem[widx(ad)];
            if (ad[0]) res = res >> 8;
            set_result_cc(dr, sx(res, 8));
            mdl_pc = pc2;
         end
         OP_LDW: begin
            ad = a + (sx(ir, 6) << 1);
            set_result_cc(dr, mdl_mem[widx(ad)]);
            mdl_pc = pc2;
         end
         OP_STB: begin
            ad = a + sx(ir, 6);
            wi = widx(ad);
            if (ad[0]) mdl_mem[wi][15:8] = mdl_reg[dr][7:0];
            else       mdl_mem[wi][7:0]  = mdl_reg[dr][7:0];
            mdl_pc = pc2;
         end
         OP_STW: begin
            ad = a + (sx(ir, 6) << 1);
            mdl_mem[widx(ad)] = mdl_reg[dr];
            mdl_pc = pc2;
         end
         OP_JSR: begin
            tgt = ir[11] ? pc2 + (sx(ir, 11) << 1) : a;
            mdl_reg[7] = pc2;
            mdl_pc = tgt;
         end
         OP_JMP: mdl_pc = a;
         OP_SHF: begin
            if (!ir[4])     res = a << ir[3:0];
            else if (!ir[5]) res = a >> ir[3:0];
            else             res = $signed(a) >>> ir[3:0];
            set_result_cc(dr, res);
            mdl_pc = pc2;
         end
         OP_LEA: begin mdl_reg[dr] = pc2 + (sx(ir, 9) << 1); mdl_pc = pc2; end
         OP_TRAP: begin
            mdl_reg[7] = pc2;
            mdl_pc = mdl_mem[widx({7'd0, ir[7:0], 1'b0})];
         end
         default: ;
      endcase
   endfunction

   function automatic status_type predict_status(logic [2:0] kind, logic [15:0] ad,
                                                 logic [15:0] wd, logic [2:0] ri);
      status_type s;
      s.read_data = 16'h0;
      case (kind)
         KIND_WRITE:   mdl_mem[widx(ad)] = wd;
         KIND_READ:    s.read_data = mdl_mem[widx(ad)];
         KIND_REGRD:   s.read_data = mdl_reg[ri];
         KIND_RESTART: begin
            foreach (mdl_reg[i]) mdl_reg[i] = 16'h0;
            mdl_pc = mdl_start_pc;
            {mdl_n, mdl_z, mdl_p} = 3'b010;
            mdl_halt = 1'b0;
         end
         KIND_EXEC:    model_execute();
         default: ;
      endcase
      s.pc_now = mdl_pc;
      s.n = mdl_n;
      s.z = mdl_z;
      s.p = mdl_p;
      s.halted = mdl_halt;
      return s;
   endfunction

   task automatic idle_gap();
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic send_request(logic [2:0] kind, logic [15:0] ad,
                               logic [15:0] wd, logic [2:0] ri);
      idle_gap();
      while (busy) @(posedge clock);
      start          <= 1'b1;
      req_kind       <= kind;
      req_address    <= ad;
      req_write_data <= wd;
      req_reg_index  <= ri;
      expected_status_q.push_back(predict_status(kind, ad, wd, ri));
      @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_start_pc(logic [15:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      mdl_start_pc = v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      status_type e;
      if (!reset && rsp_valid) begin
         if (expected_status_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = expected_status_q.pop_front();
            if (rsp_read_data !== e.read_data) begin
               $error("read_data exp %h got %h", e.read_data, rsp_read_data); errors++;
            end
            if (rsp_pc_now !== e.pc_now) begin
               $error("pc_now exp %h got %h", e.pc_now, rsp_pc_now); errors++;
            end
            if (rsp_flag_n !== e.n) begin
               $error("flag_n exp %b got %b", e.n, rsp_flag_n); errors++;
            end
            if (rsp_flag_z !== e.z) begin
               $error("flag_z exp %b got %b", e.z, rsp_flag_z); errors++;
            end
            if (rsp_flag_p !== e.p) begin
               $error("flag_p exp %b got %b", e.p, rsp_flag_p); errors++;
            end
            if (rsp_halted !== e.halted) begin
               $error("halted exp %b got %b", e.halted, rsp_halted); errors++;
            end
         end
      end
   end

   function automatic logic [15:0] rand_instr();
      logic [15:0] ir;
      ir = 16'($urandom);
      // bias memory ops toward small offsets from the base register
      if (ir[15:12] inside {OP_LDB, OP_LDW, OP_STB, OP_STW} && $urandom_range(0, 1))
         ir[5:0] = 6'($urandom_range(0, 7));
      return ir;
   endfunction

   task automatic test_directed();
      logic [15:0] prog [21] = '{
         16'h1025, 16'h1220, 16'h103F, 16'h5260, 16'h967F, 16'h0E02, 16'h0000,
         16'hE3FF, 16'h7040, 16'h2041, 16'h6440, 16'h3041, 16'hD40F, 16'hD21F,
         16'hD03F, 16'h8000, 16'hA000, 16'hB000, 16'h4802, 16'h41C0, 16'hC1C0};
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);   // execute at PC zero halts
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
      write_start_pc(16'h3001);                       // odd start
      foreach (prog[i]) send_request(KIND_WRITE, 16'h3000 + 16'(2*i), prog[i], 3'd0);
      send_request(KIND_WRITE, 16'hFFFF, 16'hFFFF, 3'd7);
      send_request(KIND_READ, 16'hFFFE, 16'h0, 3'd0);
      send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
      repeat ($size(prog)) send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
      for (int r = 0; r < 8; r++) send_request(KIND_REGRD, 16'h0, 16'h0, 3'(r));
      send_request(3'd5, 16'hFFFF, 16'hFFFF, 3'd7);
      send_request(3'd7, 16'h0, 16'h0, 3'd0);
   endtask

   task automatic test_trap();
      write_start_pc(16'h0100);
      send_request(KIND_WRITE, 16'h0100, 16'hF0FF, 3'd0);
      send_request(KIND_WRITE, 16'h01FE, 16'h0200, 3'd0);
      send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
      send_request(KIND_REGRD, 16'h0, 16'h0, 3'd7);
   endtask

   task automatic test_start_pc_edges();
      write_start_pc(16'hFFFF);
      send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
      write_start_pc(16'h0000);
      send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
   endtask

   task automatic test_random_programs(int n_items);
      int sent;
      logic [15:0] base;
      sent = 0;
      while (sent < n_items) begin
         base = {4'($urandom), 11'($urandom), 1'b0};
         if (base == 16'h0) base = 16'h0040;
         write_start_pc($urandom_range(0, 7) == 0 ? 16'($urandom) : base);
         for (int i = 0; i < 24; i++) begin
            send_request(KIND_WRITE, base + 16'(2*i), rand_instr(), 3'd0);
            sent++;
         end
         send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
         // mix execution with reads, program rewrites and stray kinds
         for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 9))
               0: send_request(KIND_READ, 16'($urandom), 16'h0, 3'd0);
               1: send_request(KIND_REGRD, 16'h0, 16'h0, 3'($urandom));
               2: send_request(KIND_WRITE, base + 16'(2*$urandom_range(0, 23)),
                               rand_instr(), 3'd0);
               3: send_request(3'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
               default: send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
            endcase
            sent++;
         end
      end
   endtask

   task automatic test_pause_for_drain();
      drain();
      send_request(KIND_RESTART, 16'h0, 16'h0, 3'd0);
      send_request(KIND_EXEC, 16'h0, 16'h0, 3'd0);
   endtask

   initial begin
      errors = 0;
      idle_enable = 1'b1;
      foreach (mdl_mem[i]) mdl_mem[i] = 16'h0;
      foreach (mdl_reg[i]) mdl_reg[i] = 16'h0;
      mdl_pc = 16'h0;
      {mdl_n, mdl_z, mdl_p} = 3'b010;
      mdl_halt = 1'b0;
      mdl_start_pc = 16'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_trap();
      test_pause_for_drain();
      test_start_pc_edges();
      test_random_programs(1400);
      idle_enable = 1'b0;
      test_random_programs(300);
      drain();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/lc3b_pkg.sv
sv/lc3b_instruction_executor_core.sv
sim/lc3b_instruction_executor_core_tb.sv
